// File: sv/gfc_pkg.sv
// Shared types, constants and helpers for the GIF frame counter.
`timescale 1ns / 1ps
package gfc_pkg;

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] FRAME_MAX = (COUNT_BITS > 16) ? COUNT_BITS'(32'hFFFF)
                                                                  : {COUNT_BITS{1'b1}};

  localparam logic [7:0] BYTE_EXT     = 8'h21;
  localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
  localparam logic [9:0] HDR_LAST_IDX = 10'd12;
  localparam logic [9:0] HDR_W_LO     = 10'd6;
  localparam logic [9:0] HDR_W_HI     = 10'd7;
  localparam logic [9:0] HDR_H_LO     = 10'd8;
  localparam logic [9:0] HDR_H_HI     = 10'd9;
  localparam logic [9:0] HDR_PACKED   = 10'd10;
  localparam logic [9:0] DESC_REMAIN  = 10'd9;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_GTAB    = 4'd1,
    PH_BLOCK   = 4'd2,
    PH_EXTLBL  = 4'd3,
    PH_DESC    = 4'd4,
    PH_LTAB    = 4'd5,
    PH_LZW     = 4'd6,
    PH_SUBLEN  = 4'd7,
    PH_SUBDATA = 4'd8,
    PH_DONE    = 4'd9
  } gfc_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } gfc_item_t;

  // Color table size in bytes: 3 * 2^(n+1) when the table flag is set.
  function automatic logic [9:0] table_len(input logic [7:0] packed_byte);
    logic [9:0] base;
    logic [3:0] sh;
    base = 10'd3;
    sh   = {1'b0, packed_byte[2:0]} + 4'd1;
    if (!packed_byte[7]) begin
      return 10'd0;
    end
    return base << sh;
  endfunction

endpackage

// File: sv/gfc_in_if.sv
// Input byte channel: valid/ready handshake with file byte and last flag.
`timescale 1ns / 1ps
interface gfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// File: sv/gfc_out_if.sv
// Result channel: valid/ready handshake carrying the per-file report.
`timescale 1ns / 1ps
interface gfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] canvas_width;
  logic [15:0] canvas_height;
  logic [15:0] frame_count;
  logic        is_animated;

  modport source(output valid, output canvas_width, output canvas_height,
                 output frame_count, output is_animated, input ready);
  modport sink(input valid, input canvas_width, input canvas_height,
               input frame_count, input is_animated, output ready);
endinterface

// File: sv/gif_frame_counter_core.sv
// Top level of the GIF frame counter: input register feeding the block walker.
// The walker registers the report when it takes the last byte from the input register.
// Throughput: one byte per cycle; a pending report stalls input only when
// a second report is due before the first is taken.
// Reset (rst, synchronous): parse state to header phase, all holds and counts to zero.
// After each report the parse state returns to its reset values.
`timescale 1ns / 1ps
module gif_frame_counter_core
  import gfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  gfc_in_if.sink    in_word,
  gfc_out_if.source out_word
);

  gfc_item_t item;
  logic      take;

  gfc_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_word),
    .take    (take),
    .item    (item)
  );

  gfc_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .take     (take),
    .out_word (out_word)
  );

endmodule

// File: sv/gfc_in_reg.sv
// Input register stage: holds one incoming word until the walker takes it.
`timescale 1ns / 1ps
module gfc_in_reg
  import gfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  gfc_in_if.sink    in_word,
  input  logic      take,
  output gfc_item_t item
);

  logic      load;
  gfc_item_t stage;

  assign in_word.ready = !stage.valid || take;
  assign load          = in_word.valid && in_word.ready;
  assign item          = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (load) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
    if (load) begin
      stage.data <= in_word.data_byte;
      stage.last <= in_word.last_byte;
    end
  end

endmodule

// File: sv/gfc_walker.sv
// Block walker: parse state update per byte and the registered report.
`timescale 1ns / 1ps
module gfc_walker
  import gfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  gfc_item_t item,
  output logic      take,
  gfc_out_if.source out_word
);

  gfc_phase_t            phase, phase_next;
  logic [9:0]            countdown, countdown_next;
  logic [9:0]            pending, pending_next;
  logic [15:0]           width_hold, width_next;
  logic [15:0]           height_hold, height_next;
  logic [COUNT_BITS-1:0] frames, frames_next;
  logic [9:0]            dec;
  logic [9:0]            tlen;
  logic                  out_free;
  logic                  report;
  logic                  short_file;

  assign out_free = !out_word.valid || out_word.ready;
  assign take     = item.valid && (!item.last || out_free);
  assign report   = take && item.last;
  assign dec      = (countdown != 10'd0) ? countdown - 10'd1 : 10'd0;
  assign tlen     = table_len(item.data);

  always_comb begin
    phase_next     = phase;
    countdown_next = countdown;
    pending_next   = pending;
    width_next     = width_hold;
    height_next    = height_hold;
    frames_next    = frames;
    unique case (phase)
      PH_HEADER: begin
        if (countdown == HDR_W_LO) width_next[7:0] = item.data;
        else if (countdown == HDR_W_HI) width_next[15:8] = item.data;
        else if (countdown == HDR_H_LO) height_next[7:0] = item.data;
        else if (countdown == HDR_H_HI) height_next[15:8] = item.data;
        else if (countdown == HDR_PACKED) pending_next = tlen;
        if (countdown >= HDR_LAST_IDX) begin
          countdown_next = pending;
          phase_next     = (pending != 10'd0) ? PH_GTAB : PH_BLOCK;
        end else begin
          countdown_next = countdown + 10'd1;
        end
      end
      PH_GTAB, PH_LTAB, PH_SUBDATA: begin
        countdown_next = dec;
        if (dec == 10'd0) begin
          if (phase == PH_GTAB) phase_next = PH_BLOCK;
          else if (phase == PH_LTAB) phase_next = PH_LZW;
          else phase_next = PH_SUBLEN;
        end
      end
      PH_BLOCK: begin
        if (item.data == BYTE_EXT) begin
          phase_next = PH_EXTLBL;
        end else if (item.data == BYTE_IMAGE) begin
          phase_next     = PH_DESC;
          countdown_next = DESC_REMAIN;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_EXTLBL, PH_LZW: begin
        phase_next = PH_SUBLEN;
      end
      PH_DESC: begin
        countdown_next = dec;
        if (dec == 10'd0) begin
          if (frames < FRAME_MAX) frames_next = frames + 1'b1;
          countdown_next = tlen;
          phase_next     = (tlen != 10'd0) ? PH_LTAB : PH_LZW;
        end
      end
      PH_SUBLEN: begin
        if (item.data == 8'd0) begin
          phase_next = PH_BLOCK;
        end else begin
          countdown_next = {2'b00, item.data};
          phase_next     = PH_SUBDATA;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  assign short_file = (phase_next == PH_HEADER);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      countdown      <= 10'd0;
      pending        <= 10'd0;
      width_hold     <= 16'd0;
      height_hold    <= 16'd0;
      frames         <= '0;
      out_word.valid <= 1'b0;
    end else begin
      if (report) begin
        phase       <= PH_HEADER;
        countdown   <= 10'd0;
        pending     <= 10'd0;
        width_hold  <= 16'd0;
        height_hold <= 16'd0;
        frames      <= '0;
      end else if (take) begin
        phase       <= phase_next;
        countdown   <= countdown_next;
        pending     <= pending_next;
        width_hold  <= width_next;
        height_hold <= height_next;
        frames      <= frames_next;
      end
      if (report) begin
        out_word.valid <= 1'b1;
      end else if (out_word.ready) begin
        out_word.valid <= 1'b0;
      end
    end
    if (report) begin
      out_word.canvas_width  <= short_file ? 16'd0 : width_next;
      out_word.canvas_height <= short_file ? 16'd0 : height_next;
      out_word.frame_count   <= short_file ? 16'd0 : 16'(frames_next);
      out_word.is_animated   <= !short_file && (frames_next >= COUNT_BITS'(2));
    end
  end

endmodule

// File: sv/gfc_checker.sv
// Port-level checks for the GIF frame counter, bound to the top level.
`timescale 1ns / 1ps
module gfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] frame_count,
  input logic        is_animated
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_count))
    else $error("result word dropped or changed while stalled");

  a_animated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_animated == (frame_count >= 16'd2)))
    else $error("animated flag disagrees with frame count");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule

bind gif_frame_counter_core gfc_checker u_gfc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_word.ready),
  .out_valid   (out_word.valid),
  .out_ready   (out_word.ready),
  .frame_count (out_word.frame_count),
  .is_animated (out_word.is_animated)
);
